// ===== rtl/lrp_pkg.sv =====
package lrp_pkg;

    localparam int NUM_STATES_DEF      = 256;
    localparam int NUM_SYMBOLS_DEF     = 64;
    localparam int NUM_PRODUCTIONS_DEF = 256;
    localparam int STACK_DEPTH_DEF     = 256;
    localparam int MAX_BODY_DEF        = 16;
    localparam int REDUCE_LIMIT_DEF    = 255;

    typedef enum logic [2:0] {
        MODE_ACT_WR  = 3'd0,
        MODE_GOTO_WR = 3'd1,
        MODE_PROD_WR = 3'd2,
        MODE_TOKEN   = 3'd3,
        MODE_BEGIN   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STS_DONE     = 3'd0,
        STS_SHIFT    = 3'd1,
        STS_ACCEPT   = 3'd2,
        STS_SYNTAX   = 3'd3,
        STS_OVERFLOW = 3'd4,
        STS_GOTO     = 3'd5,
        STS_LIMIT    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LKA,
        ST_AEV,
        ST_PEV,
        ST_SEV,
        ST_LKG,
        ST_GEV
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] state_index;
        logic [5:0] symbol_index;
        logic [7:0] production_index;
        logic [1:0] action_kind;
        logic [7:0] action_target;
        logic       entry_valid;
        logic [4:0] body_length;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] reductions;
        logic [7:0] top_state;
        logic       parse_finished;
    } t_out;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] target;
    } t_act;

    typedef struct packed {
        logic       valid;
        logic [7:0] target;
    } t_goto;

    typedef struct packed {
        logic  act_we;
        logic  goto_we;
        t_act  act;
        t_goto gto;
    } t_tbl_wr;

endpackage

// ===== rtl/lrp_tbl.sv =====
module lrp_tbl #(
    parameter int AW = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrp_pkg::t_tbl_wr i_wr,
    input  logic [AW-1:0]    i_waddr,
    input  logic [AW-1:0]    i_act_raddr,
    input  logic [AW-1:0]    i_goto_raddr,
    output lrp_pkg::t_act    o_act,
    output lrp_pkg::t_goto   o_goto,
    output logic             o_busy
);
    import lrp_pkg::*;

    localparam int DEPTH = 2 ** AW;

    t_act  act_mem  [DEPTH];
    t_goto goto_mem [DEPTH];

    logic [AW-1:0] r_clr;
    logic          r_busy;
    t_act          r_act;
    t_goto         r_goto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            act_mem[r_clr] <= '0;
        end else if (i_wr.act_we) begin
            act_mem[i_waddr] <= i_wr.act;
        end
        r_act <= act_mem[i_act_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            goto_mem[r_clr] <= '0;
        end else if (i_wr.goto_we) begin
            goto_mem[i_waddr] <= i_wr.gto;
        end
        r_goto <= goto_mem[i_goto_raddr];
    end

    assign o_act  = r_act;
    assign o_goto = r_goto;
    assign o_busy = r_busy;

endmodule

// ===== rtl/lr_parse_driver.sv =====
// Table-write and begin transactions: result valid in the cycle after acceptance.
// Token transactions: LKA, AEV, then per reduction PEV, SEV, LKG, GEV, one at a time.
// Action, goto, production and stack reads each go through one registered memory port.
// After reset the action and goto tables are cleared, one entry a cycle over all
// NUM_STATES*NUM_SYMBOLS entries (rounded up to a power of two); not ready meanwhile.
// Reset leaves an empty parse: stack holds state zero, finished flag low.
module lr_parse_driver #(
    parameter int NUM_STATES      = lrp_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS     = lrp_pkg::NUM_SYMBOLS_DEF,
    parameter int NUM_PRODUCTIONS = lrp_pkg::NUM_PRODUCTIONS_DEF,
    parameter int STACK_DEPTH     = lrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_BODY        = lrp_pkg::MAX_BODY_DEF,
    parameter int REDUCE_LIMIT    = lrp_pkg::REDUCE_LIMIT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lrp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lrp_pkg::t_out o_out_data
);
    import lrp_pkg::*;

    localparam int AW  = $clog2(NUM_STATES * NUM_SYMBOLS);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int PW  = $clog2(STACK_DEPTH + 1);
    localparam int LW  = $clog2(MAX_BODY + 1);
    localparam int CW  = $clog2(REDUCE_LIMIT + 1);
    localparam int PIW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;

    typedef struct packed {
        logic [5:0]    head;
        logic [LW-1:0] len;
    } t_prod;

    t_prod      prod_mem [NUM_PRODUCTIONS];
    logic [7:0] stk_mem  [STACK_DEPTH];

    t_state        r_state, n_state;
    logic [PW-1:0] r_sp, n_sp;
    logic [7:0]    r_top, n_top;
    logic          r_fin, n_fin;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [5:0]    r_sym, n_sym;
    logic [5:0]    r_head, n_head;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;
    logic          r_aoor, r_goor;
    t_prod         r_prod;
    logic [7:0]    r_stk_q;
    logic          r_stk_z;

    t_tbl_wr       tbl_wr;
    logic [AW-1:0] tbl_waddr, act_raddr, goto_raddr;
    t_act          act_q;
    t_goto         goto_q;
    logic          busy;

    logic           prod_we;
    logic [PIW-1:0] prod_waddr, prod_raddr;
    t_prod          prod_wdata;
    logic           stk_we;
    logic [SW-1:0]  stk_waddr, stk_raddr;
    logic [7:0]     stk_wdata;
    logic [PW-1:0]  stk_rpos;
    logic           accept;
    logic           aoor, goor;
    logic [7:0]     red_sat;
    logic [LW-1:0]  wr_len;
    t_kind          kind;

    lrp_tbl #(.AW(AW)) u_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (tbl_wr),
        .i_waddr      (tbl_waddr),
        .i_act_raddr  (act_raddr),
        .i_goto_raddr (goto_raddr),
        .o_act        (act_q),
        .o_goto       (goto_q),
        .o_busy       (busy)
    );

    assign o_in_ready  = (r_state == ST_IDLE) && !busy && (!r_out_vld || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign tbl_waddr  = AW'(32'(i_in_data.state_index) * NUM_SYMBOLS
                            + 32'(i_in_data.symbol_index));
    assign act_raddr  = AW'(32'(r_top) * NUM_SYMBOLS + 32'(r_sym));
    assign goto_raddr = AW'(32'(r_top) * NUM_SYMBOLS + 32'(r_head));
    assign aoor       = (32'(r_top) >= NUM_STATES) || (32'(r_sym) >= NUM_SYMBOLS);
    assign goor       = (32'(r_top) >= NUM_STATES) || (32'(r_head) >= NUM_SYMBOLS);
    assign red_sat    = (32'(r_cnt) > 255) ? 8'hFF : 8'(r_cnt);
    assign wr_len     = (32'(i_in_data.body_length) > MAX_BODY) ? LW'(MAX_BODY)
                                                                 : LW'(i_in_data.body_length);
    assign prod_waddr = PIW'(32'(i_in_data.production_index));
    assign prod_wdata = '{head: i_in_data.symbol_index, len: wr_len};
    assign prod_raddr = PIW'(32'(act_q.target));
    assign stk_rpos   = r_sp - PW'(r_prod.len) - 1'b1;
    assign stk_raddr  = SW'(stk_rpos);
    assign kind       = r_aoor ? KIND_EMPTY : t_kind'(act_q.kind);

    always_ff @(posedge i_clk) begin
        if (prod_we) begin
            prod_mem[prod_waddr] <= prod_wdata;
        end
        r_prod <= prod_mem[prod_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= PW'(1);
            r_top     <= '0;
            r_fin     <= 1'b0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_sp      <= n_sp;
            r_top     <= n_top;
            r_fin     <= n_fin;
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym   <= n_sym;
        r_head  <= n_head;
        r_out   <= n_out;
        r_aoor  <= aoor;
        r_goor  <= goor;
        r_stk_z <= (stk_rpos == '0);
    end

    always_comb begin
        n_state    = r_state;
        n_sp       = r_sp;
        n_top      = r_top;
        n_fin      = r_fin;
        n_cnt      = r_cnt;
        n_sym      = r_sym;
        n_head     = r_head;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_out_ready;
        tbl_wr     = '0;
        prod_we    = 1'b0;
        stk_we     = 1'b0;
        stk_waddr  = r_sp[SW-1:0];
        stk_wdata  = act_q.target;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_vld = 1'b1;
                    n_out     = '{status: STS_DONE, reductions: 8'd0,
                                  top_state: r_top, parse_finished: r_fin};
                    priority case (i_in_data.mode)
                        MODE_ACT_WR: begin
                            tbl_wr.act_we = (32'(i_in_data.state_index) < NUM_STATES)
                                         && (32'(i_in_data.symbol_index) < NUM_SYMBOLS);
                            tbl_wr.act    = '{kind: i_in_data.action_kind,
                                              target: i_in_data.action_target};
                        end
                        MODE_GOTO_WR: begin
                            tbl_wr.goto_we = (32'(i_in_data.state_index) < NUM_STATES)
                                          && (32'(i_in_data.symbol_index) < NUM_SYMBOLS);
                            tbl_wr.gto     = '{valid: i_in_data.entry_valid,
                                               target: i_in_data.entry_valid
                                                       ? i_in_data.action_target : 8'd0};
                        end
                        MODE_PROD_WR: begin
                            prod_we = 32'(i_in_data.production_index) < NUM_PRODUCTIONS;
                        end
                        MODE_TOKEN: begin
                            if (!r_fin) begin
                                n_out_vld = r_out_vld && !i_out_ready;
                                n_sym     = i_in_data.symbol_index;
                                n_cnt     = '0;
                                n_state   = ST_LKA;
                            end
                        end
                        MODE_BEGIN: begin
                            stk_we    = 1'b1;
                            stk_waddr = '0;
                            stk_wdata = 8'd0;
                            n_sp      = PW'(1);
                            n_top     = 8'd0;
                            n_fin     = 1'b0;
                            n_out.top_state      = 8'd0;
                            n_out.parse_finished = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LKA: n_state = ST_AEV;
            ST_AEV: begin
                n_out     = '{status: STS_DONE, reductions: red_sat,
                              top_state: r_top, parse_finished: 1'b1};
                n_out_vld = 1'b1;
                n_fin     = 1'b1;
                n_state   = ST_IDLE;
                unique case (kind)
                    KIND_EMPTY:  n_out.status = STS_SYNTAX;
                    KIND_ACCEPT: n_out.status = STS_ACCEPT;
                    KIND_SHIFT: begin
                        if (32'(r_sp) >= STACK_DEPTH) begin
                            n_out.status = STS_OVERFLOW;
                        end else begin
                            stk_we               = 1'b1;
                            n_sp                 = r_sp + 1'b1;
                            n_top                = act_q.target;
                            n_fin                = 1'b0;
                            n_out.status         = STS_SHIFT;
                            n_out.top_state      = act_q.target;
                            n_out.parse_finished = 1'b0;
                        end
                    end
                    KIND_REDUCE: begin
                        if (32'(r_cnt) >= REDUCE_LIMIT) begin
                            n_out.status = STS_LIMIT;
                        end else if (32'(act_q.target) >= NUM_PRODUCTIONS) begin
                            n_out.status = STS_GOTO;
                        end else begin
                            n_out     = r_out;
                            n_out_vld = 1'b0;
                            n_fin     = 1'b0;
                            n_state   = ST_PEV;
                        end
                    end
                    default: ;
                endcase
            end
            ST_PEV: begin
                if (32'(r_prod.len) >= 32'(r_sp)) begin
                    n_out     = '{status: STS_GOTO, reductions: red_sat,
                                  top_state: r_top, parse_finished: 1'b1};
                    n_out_vld = 1'b1;
                    n_fin     = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    n_sp    = r_sp - PW'(r_prod.len);
                    n_head  = r_prod.head;
                    n_state = ST_SEV;
                end
            end
            ST_SEV: begin
                n_top   = r_stk_z ? 8'd0 : r_stk_q;
                n_state = ST_LKG;
            end
            ST_LKG: n_state = ST_GEV;
            ST_GEV: begin
                if (r_goor || !goto_q.valid || (32'(r_sp) >= STACK_DEPTH)) begin
                    n_out     = '{status: (r_goor || !goto_q.valid) ? STS_GOTO : STS_OVERFLOW,
                                  reductions: red_sat, top_state: r_top,
                                  parse_finished: 1'b1};
                    n_out_vld = 1'b1;
                    n_fin     = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = goto_q.target;
                    n_sp      = r_sp + 1'b1;
                    n_top     = goto_q.target;
                    n_cnt     = r_cnt + 1'b1;
                    n_state   = ST_LKA;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp != '0) && (32'(r_sp) <= STACK_DEPTH))
        else $error("stack pointer out of range");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= REDUCE_LIMIT)
        else $error("reduction count past limit");

    a_err_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status != STS_DONE) && (r_out.status != STS_SHIFT))
        |-> r_out.parse_finished)
        else $error("error or accept without finished flag");

    a_no_rdy_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_in_ready)
        else $error("ready during table clear");

endmodule
